>>> rtl/ctb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank package
// Shared types and constants for the command front end, the slot sequencer
// and the top level.
// ----------------------------------------------------------------------------
package ctb_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_START   = 3'd2,
    OP_PAUSE   = 3'd3,
    OP_RESUME  = 3'd4,
    OP_DESTROY = 3'd5,
    OP_QUERY   = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_SLOT  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_EXPIRED   = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    op_e         op;
    kind_e       kind;
    logic [3:0]  idx;
    logic [31:0] timeout;
    logic        periodic;
    logic [15:0] handler;
    logic [31:0] qgen;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic [31:0] gen;
    logic [15:0] handler;
    logic        valid;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] time_left;
    logic [31:0] reload;
    logic [31:0] gen;
    logic [15:0] handler;
    logic        run;
    logic        pause;
    logic        periodic;
  } entry_t;

  localparam logic [15:0] TICK_STEP_RESET = 16'd100;
  localparam int unsigned OUT_LIMIT       = 16;

endpackage

>>> rtl/ctb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank command front end
// Accepts input words, classifies the operation and buffers the decoded
// command in a two-entry queue for the slot sequencer.
// ----------------------------------------------------------------------------
module ctb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [3:0]         timer_index_i,
  input  logic [31:0]        timeout_i,
  input  logic               periodic_mode_i,
  input  logic [15:0]        handler_tag_i,
  input  logic [31:0]        query_generation_i,
  output logic               cmd_valid_o,
  output ctb_pkg::cmd_t      cmd_o,
  input  logic               cmd_pop_i
);

  ctb_pkg::cmd_t  fifo_q [2];
  ctb_pkg::cmd_t  cmd_in;
  ctb_pkg::kind_e kind;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push;
  logic           pop;

  always_comb begin
    case (ctb_pkg::op_e'(operation_i))
      ctb_pkg::OP_TICK:  kind = ctb_pkg::KIND_TICK;
      ctb_pkg::OP_ALLOC: kind = ctb_pkg::KIND_ALLOC;
      ctb_pkg::OP_START, ctb_pkg::OP_PAUSE, ctb_pkg::OP_RESUME,
      ctb_pkg::OP_DESTROY, ctb_pkg::OP_QUERY: kind = ctb_pkg::KIND_SLOT;
      default:           kind = ctb_pkg::KIND_NOP;
    endcase
  end

  always_comb begin
    cmd_in.op       = ctb_pkg::op_e'(operation_i);
    cmd_in.kind     = kind;
    cmd_in.idx      = timer_index_i;
    cmd_in.timeout  = timeout_i;
    cmd_in.periodic = periodic_mode_i;
    cmd_in.handler  = handler_tag_i;
    cmd_in.qgen     = query_generation_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> rtl/ctb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank slot sequencer
// Executes queued commands against the slot memory, walks the allocated
// slots on a tick and drives the registered result word.
// ----------------------------------------------------------------------------
module ctb_back #(
  parameter int unsigned TIMER_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        tick_step_i,
  input  logic               cmd_valid_i,
  input  ctb_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  output ctb_pkg::res_t      res_o,
  input  logic               out_stall_i
);

  localparam int unsigned AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned CW = $clog2(TIMER_COUNT + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMD  = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;

  ctb_pkg::entry_t mem [TIMER_COUNT];
  ctb_pkg::entry_t rd_q;

  logic [1:0]      state_q, state_d;
  ctb_pkg::cmd_t   cmd_q, cmd_d;
  logic [CW-1:0]   alloc_q, alloc_d;
  logic [CW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]   ex_ptr_q, ex_ptr_d;
  logic            pv_q, pv_d;
  ctb_pkg::res_t   pend_q, pend_d;
  logic            pend_v_q, pend_v_d;
  logic [4:0]      cnt_q, cnt_d;
  ctb_pkg::res_t   out_q, out_d;
  logic            out_v_q, out_v_d;

  logic            out_free;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  ctb_pkg::entry_t wr_data;
  logic            push;
  ctb_pkg::res_t   push_res;

  ctb_pkg::entry_t cmd_entry;
  ctb_pkg::res_t   cmd_res;
  logic            cmd_wr;
  logic [31:0]     step_ext;
  logic [31:0]     dec;
  logic            active;
  logic            expire;
  logic            take;
  logic            hold;
  ctb_pkg::entry_t tick_entry;
  ctb_pkg::res_t   exp_res;

  assign out_free = !out_v_q || !out_stall_i;
  assign step_ext = {16'd0, tick_step_i};

  // Command execution on the entry read in the pop cycle.
  always_comb begin
    cmd_entry = rd_q;
    cmd_wr    = 1'b0;
    cmd_res   = '0;
    cmd_res.last = 1'b1;
    case (cmd_q.kind)
      ctb_pkg::KIND_ALLOC: begin
        if (alloc_q == CW'(TIMER_COUNT)) begin
          cmd_res.status = ctb_pkg::STAT_FULL;
        end else begin
          cmd_entry      = '0;
          cmd_wr         = 1'b1;
          cmd_res.status = ctb_pkg::STAT_DONE;
          cmd_res.slot   = 4'(alloc_q);
        end
      end
      ctb_pkg::KIND_SLOT: begin
        cmd_res.slot = cmd_q.idx;
        if (32'(cmd_q.idx) >= 32'(alloc_q)) begin
          cmd_res.status = ctb_pkg::STAT_BAD_INDEX;
        end else begin
          cmd_res.status = ctb_pkg::STAT_DONE;
          cmd_wr         = 1'b1;
          case (cmd_q.op)
            ctb_pkg::OP_START: begin
              cmd_entry.gen       = rd_q.gen + 32'd1;
              cmd_entry.handler   = cmd_q.handler;
              cmd_entry.reload    = cmd_q.timeout;
              cmd_entry.time_left = cmd_q.timeout;
              cmd_entry.run       = 1'b1;
              cmd_entry.pause     = 1'b0;
              cmd_entry.periodic  = cmd_q.periodic;
            end
            ctb_pkg::OP_PAUSE: begin
              if (rd_q.run && !rd_q.pause) begin
                cmd_entry.gen   = rd_q.gen + 32'd1;
                cmd_entry.pause = 1'b1;
              end
            end
            ctb_pkg::OP_RESUME: begin
              if (rd_q.run && rd_q.pause) begin
                cmd_entry.pause = 1'b0;
              end
            end
            ctb_pkg::OP_DESTROY: begin
              cmd_entry.gen   = rd_q.gen + 32'd1;
              cmd_entry.run   = 1'b0;
              cmd_entry.pause = 1'b1;
            end
            ctb_pkg::OP_QUERY: begin
              cmd_res.valid = !rd_q.pause && (rd_q.gen == cmd_q.qgen) &&
                              (!rd_q.periodic || rd_q.run);
            end
            default: begin
              cmd_wr = 1'b0;
            end
          endcase
          cmd_res.gen = cmd_entry.gen;
        end
      end
      default: begin
        cmd_res.status = ctb_pkg::STAT_DONE;
      end
    endcase
  end

  // Countdown of the slot whose entry sits in the read register.
  always_comb begin
    active     = rd_q.run && !rd_q.pause;
    dec        = (rd_q.time_left > step_ext) ? (rd_q.time_left - step_ext) : 32'd0;
    expire     = active && (dec == 32'd0);
    tick_entry = rd_q;
    if (active) begin
      tick_entry.time_left = dec;
    end
    if (expire) begin
      if (rd_q.periodic) begin
        tick_entry.time_left = rd_q.reload;
      end else begin
        tick_entry.run = 1'b0;
      end
    end
    exp_res         = '0;
    exp_res.status  = ctb_pkg::STAT_EXPIRED;
    exp_res.slot    = 4'(ex_ptr_q);
    exp_res.gen     = rd_q.gen;
    exp_res.handler = rd_q.handler;
    take = pv_q && expire && (cnt_q < 5'(ctb_pkg::OUT_LIMIT));
    // An expiry waits in the pending register until the next one shows up
    // or the walk ends, so that the final one can be marked as last.
    hold = take && pend_v_q && !out_free;
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    alloc_d   = alloc_q;
    rd_ptr_d  = rd_ptr_q;
    ex_ptr_d  = ex_ptr_q;
    pv_d      = pv_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    cnt_d     = cnt_q;
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = AW'(cmd_i.idx);
    wr_en     = 1'b0;
    wr_addr   = ex_ptr_q;
    wr_data   = tick_entry;
    push      = 1'b0;
    push_res  = pend_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          rd_en     = 1'b1;
          if (cmd_i.kind == ctb_pkg::KIND_TICK) begin
            state_d  = ST_TICK;
            cnt_d    = 5'd0;
            pend_v_d = 1'b0;
            rd_addr  = '0;
            ex_ptr_d = '0;
            if (alloc_q != '0) begin
              pv_d     = 1'b1;
              rd_ptr_d = CW'(1);
            end else begin
              pv_d     = 1'b0;
              rd_ptr_d = '0;
            end
          end else begin
            state_d = ST_CMD;
          end
        end
      end
      ST_CMD: begin
        if (out_free) begin
          push     = 1'b1;
          push_res = cmd_res;
          wr_en    = cmd_wr;
          wr_data  = cmd_entry;
          state_d  = ST_IDLE;
          if (cmd_q.kind == ctb_pkg::KIND_ALLOC) begin
            wr_addr = AW'(alloc_q);
            if (cmd_wr) begin
              alloc_d = alloc_q + CW'(1);
            end
          end else begin
            wr_addr = AW'(cmd_q.idx);
          end
        end
      end
      ST_TICK: begin
        if (pv_q) begin
          if (!hold) begin
            wr_en = active;
            if (take) begin
              if (pend_v_q) begin
                push     = 1'b1;
                push_res = pend_q;
              end
              pend_d   = exp_res;
              pend_v_d = 1'b1;
              cnt_d    = cnt_q + 5'd1;
            end
            if (rd_ptr_q != alloc_q) begin
              rd_en    = 1'b1;
              rd_addr  = AW'(rd_ptr_q);
              ex_ptr_d = AW'(rd_ptr_q);
              rd_ptr_d = rd_ptr_q + CW'(1);
              pv_d     = 1'b1;
            end else begin
              pv_d = 1'b0;
            end
          end
        end else if (pend_v_q) begin
          if (out_free) begin
            push          = 1'b1;
            push_res      = pend_q;
            push_res.last = 1'b1;
            pend_v_d      = 1'b0;
            state_d       = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d   = out_q;
    out_v_d = out_v_q;
    if (push) begin
      out_d   = push_res;
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      alloc_q  <= '0;
      rd_ptr_q <= '0;
      pv_q     <= 1'b0;
      pend_v_q <= 1'b0;
      cnt_q    <= 5'd0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      alloc_q  <= alloc_d;
      rd_ptr_q <= rd_ptr_d;
      pv_q     <= pv_d;
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    ex_ptr_q <= ex_ptr_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/countdown_timer_bank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank
// A bank of TIMER_COUNT countdown timers driven by command words.
// ----------------------------------------------------------------------------
// Input words carry an operation and its operands; each word is taken when
// in_valid_i is high and in_stall_o is low, into a two-entry command queue.
// Result words leave through a register on out_valid_o/out_stall_i. Every
// command except tick gives exactly one result word; a tick gives one word
// per expiring timer in slot order, with last_result_o on the final one,
// and none when nothing expires.
// A command is a slot memory read, then an execute step that waits while
// the output is stalled and registers the result word. On a tick the single
// read port of the slot memory walks one slot per cycle unless an expiry is
// held: while the receiver stalls the output, the walk holds at the next
// expiry and the queue keeps taking words until full. tick_step is written
// through cfg_we_i/cfg_wdata_i; the user is to write it only while the bank
// is idle, which the block does not enforce. Reset empties the queue, frees
// all slots and sets tick_step to 100; a slot is written when allocated.
// ----------------------------------------------------------------------------
module countdown_timer_bank_unit #(
  parameter int unsigned TIMER_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  timer_index_i,
  input  logic [31:0] timeout_i,
  input  logic        periodic_mode_i,
  input  logic [15:0] handler_tag_i,
  input  logic [31:0] query_generation_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [31:0] slot_generation_o,
  output logic [15:0] slot_handler_o,
  output logic        is_valid_o,
  output logic        last_result_o
);

  logic [15:0]   tick_step_q, tick_step_d;
  logic          cmd_valid;
  logic          cmd_pop;
  ctb_pkg::cmd_t cmd;
  ctb_pkg::res_t res;

  assign tick_step_d = cfg_we_i ? cfg_wdata_i : tick_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q <= ctb_pkg::TICK_STEP_RESET;
    end else begin
      tick_step_q <= tick_step_d;
    end
  end

  ctb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .timer_index_i      (timer_index_i),
    .timeout_i          (timeout_i),
    .periodic_mode_i    (periodic_mode_i),
    .handler_tag_i      (handler_tag_i),
    .query_generation_i (query_generation_i),
    .cmd_valid_o        (cmd_valid),
    .cmd_o              (cmd),
    .cmd_pop_i          (cmd_pop)
  );

  ctb_back #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_step_i (tick_step_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .out_stall_i (out_stall_i)
  );

  assign status_o          = res.status;
  assign slot_o            = res.slot;
  assign slot_generation_o = res.gen;
  assign slot_handler_o    = res.handler;
  assign is_valid_o        = res.valid;
  assign last_result_o     = res.last;

endmodule

>>> rtl/ctb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ctb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [3:0]  slot_o,
  input logic [31:0] slot_generation_o,
  input logic [15:0] slot_handler_o,
  input logic        is_valid_o,
  input logic        last_result_o
);

  // A held result word keeps its status, slot, generation and last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(slot_o) && $stable(slot_generation_o) && $stable(last_result_o))
  else $error("result word changed while stalled");

  // Only tick expiries can be followed by more results of the same command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ctb_pkg::STAT_EXPIRED) |-> last_result_o)
  else $error("command result not marked last");

  // A full table reports slot zero and generation zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ctb_pkg::STAT_FULL) |->
    (slot_o == 4'd0) && (slot_generation_o == 32'd0) && !is_valid_o)
  else $error("full table result carries slot data");

  // A positive validity answer only comes from a completed query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_valid_o |->
    (status_o == ctb_pkg::STAT_DONE) && (slot_handler_o == 16'd0))
  else $error("validity flag on a non-query result");

endmodule

bind countdown_timer_bank_unit ctb_checker u_ctb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .slot_o            (slot_o),
  .slot_generation_o (slot_generation_o),
  .slot_handler_o    (slot_handler_o),
  .is_valid_o        (is_valid_o),
  .last_result_o     (last_result_o)
);
